[rtl/core/sscu_pkg.sv]
// Package for the scanline stripe counter: widths, register map, reset values
// and the saturating counter helper. No dependencies.
package sscu_pkg;

    localparam int MAX_LINE_PIXELS = 1024;
    localparam int LEN_W           = $clog2(MAX_LINE_PIXELS + 1);

    localparam int PIXEL_W  = 8;
    localparam int FIELD_W  = 11;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [PIXEL_W-1:0] THRESHOLD_RST = 8'd100;
    localparam logic [FIELD_W-1:0] MIN_RUN_RST   = 11'd3;
    localparam logic [FIELD_W-1:0] MAX_RUN_RST   = 11'd20;
    localparam logic [FIELD_W-1:0] MIN_CNT_RST   = 11'd5;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_MIN_RUN   = 2'd1,
        REG_MAX_RUN   = 2'd2,
        REG_MIN_CNT   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] threshold;
        logic [FIELD_W-1:0] min_run_width;
        logic [FIELD_W-1:0] max_run_width;
        logic [FIELD_W-1:0] min_stripe_count;
    } cfg_t;

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v >= LEN_W'(MAX_LINE_PIXELS))
            r = LEN_W'(MAX_LINE_PIXELS);
        else
            r = v + 1'b1;
        return r;
    endfunction

endpackage

[rtl/core/sscu_if.sv]
// Valid/ready channel interfaces for pixel input and line result output.
// Depends on sscu_pkg.
interface sscu_pixel_if;
    import sscu_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               last_pixel;

    modport source (output valid, output pixel, output last_pixel, input ready);
    modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface sscu_result_if;
    import sscu_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [FIELD_W-1:0] stripe_count;
    logic [FIELD_W-1:0] run_count;

    modport source (output valid, output found, output stripe_count, output run_count,
                    input ready);
    modport sink   (input valid, input found, input stripe_count, input run_count,
                    output ready);
endinterface

[rtl/core/scanline_stripe_counter_unit.sv]
// Scanline stripe counter top level: input register, run tracking, result register.
// Depends on sscu_pkg, sscu_if and sscu_cfg.
// Result: a last pixel passes the input register, then the result register once that is free.
// Throughput: one pixel per cycle; a last pixel waits in the input register only while
// the previous result is still held and not taken.
// Reset: asynchronous, registers to their reset values, line state cleared at once.
module scanline_stripe_counter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sscu_pkg::APB_AW-1:0] paddr,
    input  logic [sscu_pkg::APB_DW-1:0] pwdata,
    output logic [sscu_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    sscu_pixel_if.sink                  pix,
    sscu_result_if.source               res
);
    import sscu_pkg::*;

    cfg_t cfg;

    sscu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage
    logic               in_valid_reg;
    logic [PIXEL_W-1:0] in_pixel_reg;
    logic               in_last_reg;

    // line state
    logic               colour_reg, colour_next;
    logic               started_reg, started_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   stripes_reg, stripes_next;
    logic [LEN_W-1:0]   runs_reg, runs_next;

    // result stage
    logic               res_valid_reg;
    logic               found_reg, found_next;
    logic [FIELD_W-1:0] stripe_cnt_reg, stripe_cnt_next;
    logic [FIELD_W-1:0] run_cnt_reg, run_cnt_next;

    logic               out_free;
    logic               stage_fire;
    logic               colour;
    logic               close_mid;
    logic [LEN_W-1:0]   len_new;
    logic [LEN_W-1:0]   stripes_mid;
    logic [LEN_W-1:0]   runs_mid;
    logic [LEN_W-1:0]   stripes_fin;
    logic [LEN_W-1:0]   runs_fin;

    assign out_free   = !res_valid_reg || res.ready;
    assign stage_fire = in_valid_reg && (!in_last_reg || out_free);
    assign pix.ready  = !in_valid_reg || stage_fire;

    assign res.valid        = res_valid_reg;
    assign res.found        = found_reg;
    assign res.stripe_count = stripe_cnt_reg;
    assign res.run_count    = run_cnt_reg;

    always_comb
    begin
        colour    = in_pixel_reg > cfg.threshold;
        close_mid = started_reg && (colour != colour_reg);
        if (!started_reg || close_mid)
            len_new = LEN_W'(1);
        else
            len_new = sat_inc(len_reg);

        runs_mid    = close_mid ? sat_inc(runs_reg) : runs_reg;
        stripes_mid = stripes_reg;
        if (close_mid && len_reg >= cfg.min_run_width && len_reg <= cfg.max_run_width)
            stripes_mid = sat_inc(stripes_reg);

        runs_fin    = sat_inc(runs_mid);
        stripes_fin = stripes_mid;
        if (len_new >= cfg.min_run_width && len_new <= cfg.max_run_width)
            stripes_fin = sat_inc(stripes_mid);

        found_next      = stripes_fin >= cfg.min_stripe_count;
        stripe_cnt_next = FIELD_W'(stripes_fin);
        run_cnt_next    = FIELD_W'(runs_fin);

        if (in_last_reg)
        begin
            colour_next  = 1'b0;
            started_next = 1'b0;
            len_next     = '0;
            stripes_next = '0;
            runs_next    = '0;
        end
        else
        begin
            colour_next  = colour;
            started_next = 1'b1;
            len_next     = len_new;
            stripes_next = stripes_mid;
            runs_next    = runs_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            colour_reg    <= 1'b0;
            started_reg   <= 1'b0;
            len_reg       <= '0;
            stripes_reg   <= '0;
            runs_reg      <= '0;
        end
        else
        begin
            if (pix.ready)
                in_valid_reg <= pix.valid;
            if (stage_fire)
            begin
                colour_reg  <= colour_next;
                started_reg <= started_next;
                len_reg     <= len_next;
                stripes_reg <= stripes_next;
                runs_reg    <= runs_next;
            end
            if (stage_fire && in_last_reg)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.ready && pix.valid)
        begin
            in_pixel_reg <= pix.pixel;
            in_last_reg  <= pix.last_pixel;
        end
        if (stage_fire && in_last_reg)
        begin
            found_reg      <= found_next;
            stripe_cnt_reg <= stripe_cnt_next;
            run_cnt_reg    <= run_cnt_next;
        end
    end

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(stage_fire && in_last_reg))
        else $error("result raised without a last pixel");

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && in_last_reg) |=> (!started_reg && runs_reg == '0))
        else $error("line state not cleared after last pixel");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LINE_PIXELS))
        else $error("run length beyond saturation");

    a_stripes_le_runs: assert property (@(posedge clk) disable iff (!rst_n)
        stripes_reg <= runs_reg)
        else $error("more stripes than runs");

    a_idle_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (len_reg == '0))
        else $error("run length set before line start");

endmodule

[rtl/core/sscu_cfg.sv]
// APB register file of the stripe counter: four configuration registers.
// Depends on sscu_pkg.
module sscu_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sscu_pkg::APB_AW-1:0] paddr,
    input  logic [sscu_pkg::APB_DW-1:0] pwdata,
    output logic [sscu_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output sscu_pkg::cfg_t             cfg
);
    import sscu_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold        <= THRESHOLD_RST;
            cfg_reg.min_run_width    <= MIN_RUN_RST;
            cfg_reg.max_run_width    <= MAX_RUN_RST;
            cfg_reg.min_stripe_count <= MIN_CNT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_THRESHOLD: cfg_reg.threshold        <= pwdata[PIXEL_W-1:0];
                REG_MIN_RUN:   cfg_reg.min_run_width    <= pwdata[FIELD_W-1:0];
                REG_MAX_RUN:   cfg_reg.max_run_width    <= pwdata[FIELD_W-1:0];
                REG_MIN_CNT:   cfg_reg.min_stripe_count <= pwdata[FIELD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_THRESHOLD: prdata = APB_DW'(cfg_reg.threshold);
            REG_MIN_RUN:   prdata = APB_DW'(cfg_reg.min_run_width);
            REG_MAX_RUN:   prdata = APB_DW'(cfg_reg.max_run_width);
            REG_MIN_CNT:   prdata = APB_DW'(cfg_reg.min_stripe_count);
            default:       prdata = '0;
        endcase
    end

endmodule

[tb/scanline_stripe_counter_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for scanline_stripe_counter_unit: a directed table of scan lines with typed
// results, then random lines under several register settings, checked by a stripe predictor.
// Depends on sscu_pkg, sscu_pixel_if, sscu_result_if and the unit's RTL.
module scanline_stripe_counter_unit_tb;
    import sscu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 3;
    localparam int END_CYCLES     = 10;
    localparam int RANDOM_PHASES  = 14;
    localparam int PRESET_COUNT   = 7;
    localparam int PHASE_PIXELS   = 20;
    localparam int DIR_ROWS       = 9;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] stripes;
        logic [FIELD_W-1:0] runs;
    } line_result_t;

    typedef struct {
        logic [PIXEL_W-1:0] px;
        bit                 last;
        int                 reps;
        bit                 typed;
        line_result_t       res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    sscu_pixel_if  pix_ch ();
    sscu_result_if res_ch ();

    scanline_stripe_counter_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_ch),
        .res     (res_ch)
    );

    // predictor copy of the registers and the line state
    logic [PIXEL_W-1:0] cfg_thr;
    logic [FIELD_W-1:0] cfg_min_w;
    logic [FIELD_W-1:0] cfg_max_w;
    logic [FIELD_W-1:0] cfg_min_cnt;
    bit                 line_open;
    bit                 run_white;
    logic [FIELD_W-1:0] run_len;
    logic [FIELD_W-1:0] stripe_tally;
    logic [FIELD_W-1:0] run_tally;

    line_result_t       line_results_due [$];
    bit                 typed_use;
    line_result_t       typed_res;

    int errors      = 0;
    int pixels_seen = 0;
    int pixels_sent;
    int lines_seen  = 0;
    int lines_found = 0;
    int reg_writes;
    int send_idle_pct;
    int recv_idle_pct;
    int holds_asked;
    int holds_done;
    int hold_left;
    int quiet_cycles;

    dir_row_t dir_rows [DIR_ROWS];
    cfg_t     presets [PRESET_COUNT];

    always #6 clk = ~clk;

    function automatic logic [FIELD_W-1:0] bump(input logic [FIELD_W-1:0] v);
        return (v >= FIELD_W'(MAX_LINE_PIXELS)) ? FIELD_W'(MAX_LINE_PIXELS) : v + 1'b1;
    endfunction

    function void tally_run();
        run_tally = bump(run_tally);
        if (run_len >= cfg_min_w && run_len <= cfg_max_w)
            stripe_tally = bump(stripe_tally);
    endfunction

    function void clear_line_state();
        line_open    = 1'b0;
        run_white    = 1'b0;
        run_len      = '0;
        stripe_tally = '0;
        run_tally    = '0;
    endfunction

    function bit take_pixel(input logic [PIXEL_W-1:0] px, input bit last,
                            output line_result_t r);
        bit white;
        white = px > cfg_thr;
        r = '0;
        if (!line_open)
        begin
            line_open = 1'b1;
            run_white = white;
            run_len   = FIELD_W'(1);
        end
        else if (white == run_white)
        begin
            run_len = bump(run_len);
        end
        else
        begin
            tally_run();
            run_white = white;
            run_len   = FIELD_W'(1);
        end
        if (!last)
            return 1'b0;
        tally_run();
        r.found   = stripe_tally >= cfg_min_cnt;
        r.stripes = stripe_tally;
        r.runs    = run_tally;
        clear_line_state();
        return 1'b1;
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_level(input bit white);
        if ($urandom_range(0, 4) == 0)
            return white ? cfg_thr + 1'b1 : cfg_thr;
        if (white && cfg_thr != 8'hFF)
            return PIXEL_W'($urandom_range(cfg_thr + 1, 255));
        return PIXEL_W'($urandom_range(0, cfg_thr));
    endfunction

    always @(posedge clk)
    begin : scoreboard
        line_result_t r;
        line_result_t due;
        line_result_t want;
        if (!rst_n)
            clear_line_state();
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            pixels_seen++;
            if (take_pixel(pix_ch.pixel, pix_ch.last_pixel, r))
            begin
                due = typed_use ? typed_res : r;
                line_results_due = {line_results_due, due};
            end
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (line_results_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %0b/%0d/%0d",
                         $time, res_ch.found, res_ch.stripe_count, res_ch.run_count);
            end
            else
            begin
                want = line_results_due.pop_front();
                lines_seen++;
                if (res_ch.found)
                    lines_found++;
                if (res_ch.found !== want.found)
                begin
                    errors++;
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $time, want.found, res_ch.found);
                end
                if (res_ch.stripe_count !== want.stripes)
                begin
                    errors++;
                    $display("%0t: stripe_count mismatch: expected %0d actual %0d",
                             $time, want.stripes, res_ch.stripe_count);
                end
                if (res_ch.run_count !== want.runs)
                begin
                    errors++;
                    $display("%0t: run_count mismatch: expected %0d actual %0d",
                             $time, want.runs, res_ch.run_count);
                end
            end
        end
    end

    // result side: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            holds_done   <= 0;
            hold_left    <= 0;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done   <= holds_done + 1;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog: %0d cycles without a transfer", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input bit last,
                              input bit typed, input line_result_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_ch.valid      <= 1'b0;
            pix_ch.pixel      <= PIXEL_W'($urandom);
            pix_ch.last_pixel <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.pixel      <= px;
        pix_ch.last_pixel <= last;
        typed_use         <= typed;
        typed_res         <= res;
        do @(posedge clk); while (!pix_ch.ready);
        pixels_sent++;
    endtask

    task automatic send_line(input int npix, input bit noisy, input bit close);
        int left;
        int run;
        int cap;
        bit white;
        logic [PIXEL_W-1:0] px;
        left  = npix;
        white = 1'($urandom_range(0, 1));
        cap   = (cfg_max_w > 22) ? 24 : cfg_max_w + 2;
        while (left > 0)
        begin
            run = $urandom_range(1, cap);
            if (run > left)
                run = left;
            repeat (run)
            begin
                px = (noisy && $urandom_range(0, 2) == 0) ? PIXEL_W'($urandom)
                                                          : pick_level(white);
                send_pixel(px, close && left == 1, 1'b0, '0);
                left--;
            end
            white = !white;
        end
    endtask

    // stop sending, let every pending result out, then give the pipeline time to empty
    task automatic settle();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (line_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_THRESHOLD: cfg_thr     = val[PIXEL_W-1:0];
            REG_MIN_RUN:   cfg_min_w   = val[FIELD_W-1:0];
            REG_MAX_RUN:   cfg_max_w   = val[FIELD_W-1:0];
            REG_MIN_CNT:   cfg_min_cnt = val[FIELD_W-1:0];
            default: ;
        endcase
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits carry junk; the registers keep only their own width
    task automatic write_setting(input cfg_t s);
        logic [APB_DW-1:0] junk;
        junk = $urandom;
        apb_write(REG_THRESHOLD, {junk[APB_DW-1:PIXEL_W], s.threshold});
        apb_write(REG_MIN_RUN,   {junk[APB_DW-1:FIELD_W], s.min_run_width});
        apb_write(REG_MAX_RUN,   {junk[APB_DW-1:FIELD_W], s.max_run_width});
        apb_write(REG_MIN_CNT,   {junk[APB_DW-1:FIELD_W], s.min_stripe_count});
    endtask

    function automatic cfg_t random_setting();
        cfg_t s;
        s.threshold        = PIXEL_W'($urandom_range(0, 255));
        s.min_run_width    = FIELD_W'($urandom_range(1, 12));
        s.max_run_width    = FIELD_W'($urandom_range(1, 24));
        s.min_stripe_count = FIELD_W'($urandom_range(0, 6));
        return s;
    endfunction

    initial
    begin
        int   p;
        int   k;
        int   start;
        int   len;
        bit   last;
        cfg_t s;

        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pix_ch.valid      = 1'b0;
        pix_ch.pixel      = '0;
        pix_ch.last_pixel = 1'b0;
        typed_use         = 1'b0;
        typed_res         = '0;
        pixels_sent       = 0;
        reg_writes        = 0;
        holds_asked       = 0;
        send_idle_pct     = 30;
        recv_idle_pct     = 49;
        cfg_thr           = THRESHOLD_RST;
        cfg_min_w         = MIN_RUN_RST;
        cfg_max_w         = MAX_RUN_RST;
        cfg_min_cnt       = MIN_CNT_RST;

        // reset values: threshold 100, window 3..20, five stripes for found
        dir_rows[0] = '{8'd0,   1'b1, 1, 1'b1, {1'b0, 11'd0, 11'd1}};
        dir_rows[1] = '{8'd255, 1'b1, 1, 1'b1, {1'b0, 11'd0, 11'd1}};
        dir_rows[2] = '{8'd100, 1'b0, 1, 1'b0, '0};
        dir_rows[3] = '{8'd101, 1'b1, 1, 1'b1, {1'b0, 11'd0, 11'd2}};
        dir_rows[4] = '{8'd0,   1'b0, 3, 1'b0, '0};
        dir_rows[5] = '{8'd255, 1'b0, 3, 1'b0, '0};
        dir_rows[6] = '{8'd0,   1'b0, 3, 1'b0, '0};
        dir_rows[7] = '{8'd255, 1'b0, 3, 1'b0, '0};
        dir_rows[8] = '{8'd0,   1'b1, 3, 1'b1, {1'b1, 11'd5, 11'd5}};

        presets[0] = '{8'd0,   11'd1,    11'd1,    11'd0};
        presets[1] = '{8'd255, 11'd1,    11'd4,    11'd1};
        presets[2] = '{8'd128, 11'd10,   11'd5,    11'd1};
        presets[3] = '{8'd60,  11'd2,    11'd6,    11'd3};
        presets[4] = '{8'd254, 11'd1024, 11'd1024, 11'd1024};
        presets[5] = '{8'd100, 11'd3,    11'd20,   11'd5};
        presets[6] = '{8'd180, 11'd1,    11'd12,   11'd2};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            for (k = 0; k < dir_rows[i].reps; k++)
            begin
                last = dir_rows[i].last && k == dir_rows[i].reps - 1;
                send_pixel(dir_rows[i].px, last, dir_rows[i].typed && last, dir_rows[i].res);
            end
        end

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            if (p == 5)
            begin
                send_idle_pct = 49;
                recv_idle_pct <= 30;
            end
            else if (p == 10)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            s = (p < PRESET_COUNT) ? presets[p] : random_setting();
            write_setting(s);
            start = pixels_sent;
            if (p == 3)
            begin
                // settings change in the middle of a line
                send_line(12, 1'b0, 1'b0);
                settle();
                write_setting('{8'd200, 11'd1, 11'd3, 11'd2});
                send_line(12, 1'b0, 1'b1);
            end
            if (p == 11)
            begin
                // receiver stalls long while short lines keep coming
                holds_asked <= holds_asked + 1;
                repeat (40) send_line($urandom_range(1, 2), 1'b0, 1'b1);
            end
            while (pixels_sent - start < PHASE_PIXELS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 40);
                send_line(len, $urandom_range(0, 6) == 0, 1'b1);
            end
        end

        // one run longer than the line maximum
        settle();
        write_setting('{8'd100, 11'd1024, 11'd1024, 11'd1});
        for (k = 0; k < 1026; k++)
            send_pixel(PIXEL_W'($urandom_range(101, 255)), k == 1025, 1'b0, '0);

        settle();
        repeat (END_CYCLES) @(posedge clk);

        $display("Run covered %0d pixels in %0d checked lines (%0d found), %0d register writes,",
                 pixels_seen, lines_seen, lines_found, reg_writes);
        $display("with empty and full-range windows, threshold extremes and a saturated run.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/sscu_pkg.sv
rtl/core/sscu_if.sv
rtl/core/sscu_cfg.sv
rtl/core/scanline_stripe_counter_unit.sv
tb/scanline_stripe_counter_unit_tb.sv
